FILE: rtl/core/assert_macros.svh
// assertion macros for the neighbour table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/nta_pkg.sv
// types, codes and defaults for the neighbour table with miss-count eviction
package nta_pkg;

  localparam int SLOTS            = 8;
  localparam int ID_BYTES_DEFAULT = 6;
  localparam int ID_W             = 48;

  localparam logic [3:0] MISS_LIMIT_RESET = 4'd3;
  localparam logic [3:0] MISS_MAX         = 4'd15;

  localparam logic [1:0] MODE_BEACON = 2'd0;
  localparam logic [1:0] MODE_AGE    = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [7:0]      rssi;
    logic [7:0]      battery;
    logic [3:0]      missed;
  } nta_entry_t;

  typedef struct packed {
    logic [3:0] count;
    logic [2:0] slot_used;
    logic       was_known;
    logic       displaced;
    logic [3:0] removed;
    logic       entry_valid;
    nta_entry_t entry;
  } nta_result_t;

endpackage

FILE: rtl/core/nta_table_ram.sv
// entry memory: one write port, one registered read port
module nta_table_ram (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(nta_pkg::SLOTS)-1:0] wr_addr,
  input  nta_pkg::nta_entry_t               wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(nta_pkg::SLOTS)-1:0] rd_addr,
  output nta_pkg::nta_entry_t               rd_data
);
  import nta_pkg::*;

  nta_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/nta_ctrl.sv
// sequencer: scans, places, compacts and reads table entries through the memory
module nta_ctrl #(
  parameter int ID_BYTES = nta_pkg::ID_BYTES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [1:0]                        mode,
  input  logic [nta_pkg::ID_W-1:0]          node_id,
  input  logic [7:0]                        rssi_lo,
  input  logic [7:0]                        battery,
  input  logic [2:0]                        entry_index,
  input  logic [3:0]                        miss_limit,
  output logic                              busy,
  output logic                              rd_en,
  output logic [$clog2(nta_pkg::SLOTS)-1:0] rd_addr,
  input  nta_pkg::nta_entry_t               rd_data,
  output logic                              wr_en,
  output logic [$clog2(nta_pkg::SLOTS)-1:0] wr_addr,
  output nta_pkg::nta_entry_t               wr_data,
  output logic                              res_valid,
  output nta_pkg::nta_result_t              res
);
  import nta_pkg::*;
  `include "assert_macros.svh"

  localparam int AW   = $clog2(SLOTS);
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > 3) ? CW : 3;
  localparam logic [ID_W-1:0] ID_MASK = (ID_BYTES >= 6) ? {ID_W{1'b1}} :
                                        ID_W'((64'd1 << (8 * ID_BYTES)) - 64'd1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_AGE   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0]      state;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   rd_ptr;
  logic            pend;
  logic [AW-1:0]   pend_addr;
  logic [CW-1:0]   wp;
  logic [CW-1:0]   removed_cnt;
  logic            hit;
  logic [AW-1:0]   hit_slot;
  logic [3:0]      best_miss;
  logic [AW-1:0]   best_slot;
  logic [ID_W-1:0] op_id;
  logic [7:0]      op_rssi;
  logic [7:0]      op_battery;

  logic            issue_ok;
  logic            rd_hit;
  logic [3:0]      miss_inc;
  logic            drop;
  logic            idx_ok;
  logic            full;
  logic [AW-1:0]   place_slot;
  logic [CW-1:0]   cnt_after;

  assign busy      = (state != S_IDLE);
  assign issue_ok  = (rd_ptr < cnt);
  assign rd_hit    = pend && (state == S_SCAN) && (rd_data.id == op_id);
  assign miss_inc  = (rd_data.missed == MISS_MAX) ? MISS_MAX : rd_data.missed + 4'd1;
  assign drop      = (miss_inc >= miss_limit);
  assign idx_ok    = (CMPW'(entry_index) < CMPW'(cnt));
  assign full      = (cnt == CW'(SLOTS));
  assign place_slot = hit ? hit_slot : (full ? best_slot : cnt[AW-1:0]);
  assign cnt_after  = (!hit && !full) ? cnt + CW'(1) : cnt;

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = rd_ptr[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = wp[AW-1:0];
    wr_data   = '0;
    res_valid = 1'b0;
    res       = '0;
    res.count = 4'(cnt);
    case (state)
      S_IDLE: begin
        if (start) begin
          if (mode == MODE_READ && idx_ok) begin
            rd_en   = 1'b1;
            rd_addr = AW'(entry_index);
          end else if (mode != MODE_BEACON && mode != MODE_AGE) begin
            // unused mode or read beyond count: answer at once
            res_valid = 1'b1;
          end
        end
      end
      S_SCAN: begin
        rd_en = issue_ok && !rd_hit;
      end
      S_PLACE: begin
        wr_en             = 1'b1;
        wr_addr           = place_slot;
        wr_data.id        = op_id;
        wr_data.rssi      = op_rssi;
        wr_data.battery   = op_battery;
        wr_data.missed    = 4'd0;
        res_valid         = 1'b1;
        res.count         = 4'(cnt_after);
        res.slot_used     = 3'(place_slot);
        res.was_known     = hit;
        res.displaced     = !hit && full;
      end
      S_AGE: begin
        rd_en = issue_ok;
        if (pend && !drop) begin
          wr_en          = 1'b1;
          wr_data        = rd_data;
          wr_data.missed = miss_inc;
        end
        if (!pend && !issue_ok) begin
          res_valid   = 1'b1;
          res.count   = 4'(wp);
          res.removed = 4'(removed_cnt);
        end
      end
      S_READ: begin
        res_valid       = 1'b1;
        res.entry_valid = 1'b1;
        res.entry       = rd_data;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      pend      <= rd_en;
      pend_addr <= rd_ptr[AW-1:0];
      if (rd_en && state != S_IDLE) begin
        rd_ptr <= rd_ptr + CW'(1);
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op_id       <= node_id & ID_MASK;
            op_rssi     <= rssi_lo;
            op_battery  <= battery;
            rd_ptr      <= '0;
            wp          <= '0;
            removed_cnt <= '0;
            hit         <= 1'b0;
            best_miss   <= '0;
            best_slot   <= '0;
            case (mode)
              MODE_BEACON: state <= S_SCAN;
              MODE_AGE:    state <= S_AGE;
              MODE_READ:   state <= idx_ok ? S_READ : S_IDLE;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (rd_hit) begin
            hit      <= 1'b1;
            hit_slot <= pend_addr;
            state    <= S_PLACE;
          end else begin
            // lowest position wins a tie on the eviction candidate
            if (pend && (pend_addr == '0 || rd_data.missed > best_miss)) begin
              best_miss <= rd_data.missed;
              best_slot <= pend_addr;
            end
            if (!pend && !issue_ok) begin
              state <= S_PLACE;
            end
          end
        end
        S_PLACE: begin
          cnt   <= cnt_after;
          state <= S_IDLE;
        end
        S_AGE: begin
          if (pend) begin
            if (drop) begin
              removed_cnt <= removed_cnt + CW'(1);
            end else begin
              wp <= wp + CW'(1);
            end
          end
          if (!pend && !issue_ok) begin
            cnt   <= wp;
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_cnt_range, clk, rst, cnt <= CW'(SLOTS), "count beyond table size")
  `ASSERT_IMPLIES(a_age_wr_behind, clk, rst, wr_en, wp <= CW'(pend_addr), "write ahead of read")
  `ASSERT_IMPLIES(a_pend_busy, clk, rst, pend, state != S_IDLE, "read data pending while idle")
  `ASSERT_NEXT(a_res_idle, clk, rst, res_valid, state == S_IDLE, "not idle after result")

endmodule

FILE: rtl/core/neighbor_table_aging.sv
// The table sits in a single-port-read memory and beacons and aging ticks walk it one entry
// per cycle: a beacon keeps busy high while it scans, waits for the last read to return and
// then writes the entry (it stops scanning early when the id is found), an aging tick while
// it reads, raises and compacts in one pass, a read while its one entry is fetched, and a
// read beyond count or an unused mode does not raise busy at all.
// The result is registered and appears on done for exactly one cycle after busy drops; it
// must be taken then, as the block cannot hold it. A new item may start in the cycle that
// its predecessor's result is shown. miss_limit resets to 3.
module neighbor_table_aging #(
  parameter int ID_BYTES = nta_pkg::ID_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [47:0]        node_id,
  input  logic signed [15:0] rssi,
  input  logic [7:0]         battery,
  input  logic [2:0]         entry_index,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  output logic               done,
  output logic [3:0]         count,
  output logic [2:0]         slot_used,
  output logic               was_known,
  output logic               displaced,
  output logic [3:0]         removed,
  output logic               entry_valid,
  output logic [47:0]        entry_id,
  output logic signed [7:0]  entry_rssi,
  output logic [7:0]         entry_battery,
  output logic [3:0]         entry_missed
);
  import nta_pkg::*;

  localparam int AW = $clog2(SLOTS);

  logic [3:0]    miss_limit;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  nta_entry_t    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  nta_entry_t    wr_data;
  logic          res_valid;
  nta_result_t   res;
  nta_result_t   res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_limit <= MISS_LIMIT_RESET;
      done       <= 1'b0;
    end else begin
      if (cfg_we) begin
        miss_limit <= cfg_wdata;
      end
      done <= res_valid;
    end
  end

  // output stage for the result item
  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign count         = res_q.count;
  assign slot_used     = res_q.slot_used;
  assign was_known     = res_q.was_known;
  assign displaced     = res_q.displaced;
  assign removed       = res_q.removed;
  assign entry_valid   = res_q.entry_valid;
  assign entry_id      = res_q.entry.id;
  assign entry_rssi    = $signed(res_q.entry.rssi);
  assign entry_battery = res_q.entry.battery;
  assign entry_missed  = res_q.entry.missed;

  nta_ctrl #(
    .ID_BYTES (ID_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .node_id     (node_id),
    .rssi_lo     (rssi[7:0]),
    .battery     (battery),
    .entry_index (entry_index),
    .miss_limit  (miss_limit),
    .busy        (busy),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  nta_table_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

FILE: bench/nta_checker.sv
// checker for the neighbour table: predicts every item's reply and compares it with done
module nta_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode,
  input  logic [47:0] node_id,
  input  logic [15:0] rssi,
  input  logic [7:0]  battery,
  input  logic [2:0]  entry_index,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        done,
  input  logic [3:0]  count,
  input  logic [2:0]  slot_used,
  input  logic        was_known,
  input  logic        displaced,
  input  logic [3:0]  removed,
  input  logic        entry_valid,
  input  logic [47:0] entry_id,
  input  logic [7:0]  entry_rssi,
  input  logic [7:0]  entry_battery,
  input  logic [3:0]  entry_missed,
  output int          mismatches,
  output int          pending
);
  import nta_pkg::*;

  localparam int NBR_SLOTS = SLOTS;

  // shadow copy of the neighbour table, valid below nbr_count
  nta_entry_t  nbr [NBR_SLOTS];
  int          nbr_count;
  logic [3:0]  limit_q;
  nta_result_t replies_due [$];
  int          bad_count;

  assign mismatches = bad_count;

  function automatic nta_result_t update_table(logic [1:0] m, logic [47:0] nid,
                                               logic [15:0] rs, logic [7:0] bat,
                                               logic [2:0] idx);
    nta_result_t r;
    int          slot;
    bit          found;
    int          i;
    int          j;
    r = '0;
    slot = 0;
    found = 1'b0;
    case (m)
      MODE_BEACON: begin
        for (i = 0; i < nbr_count; i++)
          if (!found && nbr[i].id == nid) begin
            slot = i;
            found = 1'b1;
          end
        if (!found) begin
          if (nbr_count < NBR_SLOTS) begin
            slot = nbr_count;
            nbr_count++;
          end else begin
            // table full: most misses goes, lowest position on a tie
            for (i = 1; i < NBR_SLOTS; i++)
              if (nbr[i].missed > nbr[slot].missed) slot = i;
            r.displaced = 1'b1;
          end
        end
        nbr[slot] = '{id: nid, rssi: rs[7:0], battery: bat, missed: 4'd0};
        r.slot_used = slot[2:0];
        r.was_known = found;
      end
      MODE_AGE: begin
        i = 0;
        while (i < nbr_count) begin
          if (nbr[i].missed < MISS_MAX) nbr[i].missed = nbr[i].missed + 4'd1;
          if (nbr[i].missed >= limit_q) begin
            // close the gap, the next entry is then looked at in place
            for (j = i; j + 1 < nbr_count; j++) nbr[j] = nbr[j + 1];
            nbr_count--;
            r.removed = r.removed + 4'd1;
          end else begin
            i++;
          end
        end
      end
      MODE_READ: begin
        if (idx < nbr_count) begin
          r.entry_valid = 1'b1;
          r.entry = nbr[idx];
        end
      end
      default: ;
    endcase
    r.count = nbr_count[3:0];
    return r;
  endfunction

  function automatic string fmt_reply(nta_result_t r);
    return {$sformatf("count=%0d slot=%0d known=%b displaced=%b removed=%0d",
                      r.count, r.slot_used, r.was_known, r.displaced, r.removed),
            $sformatf(" valid=%b id=%h rssi=%0d bat=%0d missed=%0d",
                      r.entry_valid, r.entry.id, $signed(r.entry.rssi), r.entry.battery,
                      r.entry.missed)};
  endfunction

  always @(posedge clk) begin : watch
    nta_result_t seen;
    nta_result_t want;
    if (rst) begin
      nbr_count = 0;
      limit_q = MISS_LIMIT_RESET;
      replies_due.delete();
      bad_count = 0;
      pending <= 0;
    end else begin
      if (done) begin
        seen = '{count: count, slot_used: slot_used, was_known: was_known,
                 displaced: displaced, removed: removed, entry_valid: entry_valid,
                 entry: '{id: entry_id, rssi: entry_rssi, battery: entry_battery,
                          missed: entry_missed}};
        if (replies_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: reply with no item awaiting it: %s", $realtime, fmt_reply(seen));
        end else begin
          want = replies_due.pop_front();
          if (seen !== want) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: reply mismatch\n  expected %s\n  actual   %s", $realtime,
                       fmt_reply(want), fmt_reply(seen));
          end
        end
      end
      if (cfg_we) limit_q = cfg_wdata;
      if (start && !busy)
        replies_due.push_back(update_table(mode, node_id, rssi, battery, entry_index));
      pending <= replies_due.size();
    end
  end

endmodule

FILE: bench/tb_neighbor_table_aging.sv
// testbench top for the neighbour table: drives items and limit writes, gives the verdict
module tb_neighbor_table_aging;
  import nta_pkg::*;

  localparam int  STALL_LIMIT = 2000;
  localparam int  SETTLE      = 12;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [47:0] ID_ONES = 48'hFFFF_FFFF_FFFF;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [47:0] node_id;
  logic [15:0] rssi;
  logic [7:0]  battery;
  logic [2:0]  entry_index;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        done;
  logic [3:0]  count;
  logic [2:0]  slot_used;
  logic        was_known;
  logic        displaced;
  logic [3:0]  removed;
  logic        entry_valid;
  logic [47:0] entry_id;
  logic [7:0]  entry_rssi;
  logic [7:0]  entry_battery;
  logic [3:0]  entry_missed;
  int          mismatches;
  int          pending;
  int          stall_cycles;
  logic [47:0] id_pool [10];

  neighbor_table_aging u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .node_id      (node_id),
    .rssi         (rssi),
    .battery      (battery),
    .entry_index  (entry_index),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .count        (count),
    .slot_used    (slot_used),
    .was_known    (was_known),
    .displaced    (displaced),
    .removed      (removed),
    .entry_valid  (entry_valid),
    .entry_id     (entry_id),
    .entry_rssi   (entry_rssi),
    .entry_battery(entry_battery),
    .entry_missed (entry_missed)
  );

  nta_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .node_id(node_id),
    .rssi(rssi), .battery(battery), .entry_index(entry_index), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .done(done), .count(count), .slot_used(slot_used),
    .was_known(was_known), .displaced(displaced), .removed(removed),
    .entry_valid(entry_valid), .entry_id(entry_id), .entry_rssi(entry_rssi),
    .entry_battery(entry_battery), .entry_missed(entry_missed),
    .mismatches(mismatches), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: cycles with neither an item nor a reply taken
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [47:0] rand_id();
    return {16'($urandom_range(16'hFFFF, 0)), $urandom()};
  endfunction

  // start stays high across back-to-back items
  task automatic send_item(logic [1:0] m, logic [47:0] nid, logic [15:0] rs,
                           logic [7:0] bat, logic [2:0] idx);
    @(negedge clk);
    start = 1'b1;
    mode = m;
    node_id = nid;
    rssi = rs;
    battery = bat;
    entry_index = idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic rest_for(int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      mode = 2'($urandom_range(3, 0));
      node_id = rand_id();
      rssi = 16'($urandom());
      battery = 8'($urandom());
      entry_index = 3'($urandom());
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_miss_limit(logic [3:0] lim);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = lim;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = 4'($urandom());
  endtask

  task automatic send_random();
    int          pick;
    logic [1:0]  m;
    logic [47:0] nid;
    pick = $urandom_range(99, 0);
    if (pick < 50) m = MODE_BEACON;
    else if (pick < 72) m = MODE_AGE;
    else if (pick < 95) m = MODE_READ;
    else m = MODE_UNUSED;
    // mostly ids from a small pool so that hits and evictions are common
    nid = ($urandom_range(9, 0) == 0) ? rand_id() : id_pool[$urandom_range(9, 0)];
    send_item(m, nid, 16'($urandom()), 8'($urandom()), 3'($urandom()));
  endtask

  task automatic run_phase(logic [3:0] lim, int n_items);
    int sent;
    int burst;
    int k;
    set_miss_limit(lim);
    for (k = 0; k < 10; k++) id_pool[k] = rand_id();
    id_pool[0] = (lim[0]) ? ID_ONES : 48'd0;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 15) : $urandom_range(10, 1);
      for (k = 0; k < burst && sent < n_items; k++) begin
        send_random();
        sent++;
      end
      if ($urandom_range(39, 0) == 0) drain();
      else if ($urandom_range(3, 0) != 0) rest_for($urandom_range(20, 1));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_BEACON;
    node_id = '0;
    rssi = '0;
    battery = '0;
    entry_index = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at the reset limit
    send_item(MODE_READ, '0, '0, '0, 3'd0);
    send_item(MODE_UNUSED, ID_ONES, 16'hFFFF, 8'hFF, 3'd7);
    send_item(MODE_BEACON, 48'd0, 16'h8000, 8'h00, 3'd0);
    send_item(MODE_BEACON, ID_ONES, 16'h7FFF, 8'hFF, 3'd0);
    send_item(MODE_BEACON, 48'd1, 16'h0080, 8'h12, 3'd0);
    send_item(MODE_BEACON, 48'd2, 16'h007F, 8'h34, 3'd0);
    send_item(MODE_BEACON, 48'd3, 16'($urandom()), 8'($urandom()), 3'd0);
    send_item(MODE_BEACON, 48'd4, 16'($urandom()), 8'($urandom()), 3'd0);
    send_item(MODE_BEACON, 48'd5, 16'($urandom()), 8'($urandom()), 3'd0);
    send_item(MODE_BEACON, 48'd6, 16'($urandom()), 8'($urandom()), 3'd0);
    // table full, all misses equal: lowest position is overwritten
    send_item(MODE_BEACON, 48'd7, 16'($urandom()), 8'($urandom()), 3'd0);
    send_item(MODE_BEACON, ID_ONES, 16'h1234, 8'h56, 3'd0);
    send_item(MODE_AGE, '0, '0, '0, 3'd0);
    send_item(MODE_BEACON, 48'd3, 16'($urandom()), 8'($urandom()), 3'd0);
    send_item(MODE_AGE, '0, '0, '0, 3'd0);
    send_item(MODE_BEACON, 48'd8, 16'($urandom()), 8'($urandom()), 3'd0);
    send_item(MODE_READ, '0, '0, '0, 3'd7);
    send_item(MODE_READ, '0, '0, '0, 3'd0);
    send_item(MODE_AGE, '0, '0, '0, 3'd0);
    send_item(MODE_READ, '0, '0, '0, 3'd0);
    send_item(MODE_READ, '0, '0, '0, 3'd7);
    send_item(MODE_READ, '0, '0, '0, 3'd2);
    send_item(MODE_UNUSED, '0, '0, '0, 3'd0);

    // limit of zero: one tick empties the table
    set_miss_limit(4'd0);
    send_item(MODE_BEACON, 48'h0000_0000_0009, 16'($urandom()), 8'($urandom()), 3'd0);
    send_item(MODE_BEACON, 48'h8000_0000_0000, 16'($urandom()), 8'($urandom()), 3'd0);
    send_item(MODE_AGE, '0, '0, '0, 3'd0);
    send_item(MODE_READ, '0, '0, '0, 3'd0);

    run_phase(4'd15, 205);
    run_phase(4'd1, 205);
    run_phase(4'($urandom_range(14, 2)), 205);
    run_phase(4'd2, 205);
    run_phase(4'd8, 205);
    run_phase(4'd3, 205);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
